// ===== rtl/core/bilinear_gradient_pixel_unit_assert.svh =====
// Assertion macros for the gradient pixel unit.
// Both expect signals named clock and reset in the enclosing module.
`ifndef BILINEAR_GRADIENT_PIXEL_UNIT_ASSERT_SVH
`define BILINEAR_GRADIENT_PIXEL_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BGP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bgp same-cycle check failed");

// Next-cycle implication.
`define BGP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bgp next-cycle check failed");

`endif

// ===== rtl/core/bgp_pkg.sv =====
`default_nettype none
package bgp_pkg;

   localparam int FRAC_BITS          = 16;
   localparam int CHAN_W             = 8;
   localparam int NUM_CHANS          = 3;
   localparam int NUM_CORNERS        = 4;
   localparam int COORD_W            = 12;
   localparam int SIZE_W             = 13;
   localparam int DIV_W              = 12;
   localparam int COLOUR_W           = NUM_CHANS * CHAN_W;
   localparam int ARGB_W             = COLOUR_W + CHAN_W;
   localparam int NUM_W              = CHAN_W + FRAC_BITS;
   localparam int STEP_W             = NUM_W + 1;
   localparam int MUL_W              = COORD_W + NUM_W;
   localparam int SUM_W              = MUL_W + 2;
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES         = NUM_W / DIV_BITS_PER_STAGE;
   localparam int BIT_CNT_W          = $clog2(NUM_W);
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = COLOUR_W;
   localparam int MIN_SIZE           = 2;
   localparam int MAX_SIZE           = 4096;

   localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

   // Corner order in the colour array
   localparam int CORNER_TL = 0;
   localparam int CORNER_BL = 1;
   localparam int CORNER_TR = 2;
   localparam int CORNER_BR = 3;

   localparam logic [SIZE_W-1:0]   RESET_WIDTH        = 13'd2388;
   localparam logic [SIZE_W-1:0]   RESET_HEIGHT       = 13'd1512;
   localparam logic [COLOUR_W-1:0] RESET_TOP_LEFT     = 24'hCCBAAE;
   localparam logic [COLOUR_W-1:0] RESET_BOTTOM_LEFT  = 24'hC1482F;
   localparam logic [COLOUR_W-1:0] RESET_TOP_RIGHT    = 24'hC1482F;
   localparam logic [COLOUR_W-1:0] RESET_BOTTOM_RIGHT = 24'hCCBAAE;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH        = 3'd0,
      REG_HEIGHT       = 3'd1,
      REG_TOP_LEFT     = 3'd2,
      REG_BOTTOM_LEFT  = 3'd3,
      REG_TOP_RIGHT    = 3'd4,
      REG_BOTTOM_RIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } req_beat_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [ARGB_W-1:0] argb_word;
   } rsp_beat_type;

   typedef struct packed {
      logic [SIZE_W-1:0]                     width;
      logic [SIZE_W-1:0]                     height;
      logic [NUM_CORNERS-1:0][COLOUR_W-1:0]  colour;
   } cfg_type;

   // step[0] is the left edge, step[1] the right edge, per channel
   typedef struct packed {
      logic                                  busy;
      logic [1:0][NUM_CHANS-1:0][STEP_W-1:0] step;
   } vstep_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_state_type;

   typedef struct packed {
      logic [NUM_CHANS-1:0][NUM_W-1:0] left;
      logic [COORD_W-1:0]              col;
      logic [NUM_CHANS-1:0]            neg;
      div_state_type [NUM_CHANS-1:0]   div;
   } hdiv_beat_type;

   function automatic logic [CHAN_W-1:0] chan_of(logic [COLOUR_W-1:0] colour, int ch);
      return colour[(NUM_CHANS - 1 - ch) * CHAN_W +: CHAN_W];
   endfunction

   // Clamp a size register and return size minus one
   function automatic logic [DIV_W-1:0] eff_div(logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] m;
      if (v < SIZE_W'(MIN_SIZE)) begin
         m = SIZE_W'(MIN_SIZE);
      end else if (v > SIZE_W'(MAX_SIZE)) begin
         m = SIZE_W'(MAX_SIZE);
      end else begin
         m = v;
      end
      m = m - SIZE_W'(1);
      return m[DIV_W-1:0];
   endfunction

   // One restoring division step; quotient bits shift in at the bottom of num
   function automatic div_state_type div_step(div_state_type s, logic [DIV_W-1:0] d);
      logic [DIV_W:0] shifted;
      logic [DIV_W:0] diff;
      div_state_type  r;
      shifted = {s.rem, s.num[NUM_W-1]};
      diff    = shifted - {1'b0, d};
      if (shifted >= {1'b0, d}) begin
         r.rem = diff[DIV_W-1:0];
         r.num = {s.num[NUM_W-2:0], 1'b1};
      end else begin
         r.rem = shifted[DIV_W-1:0];
         r.num = {s.num[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bgp_vstep_seq.sv =====
`default_nettype none
module bgp_vstep_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  bgp_pkg::cfg_type               cfg,
   input  logic [bgp_pkg::DIV_W-1:0]      hdiv,
   output bgp_pkg::vstep_type             vstep
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_RUN,
      S_STORE
   } state_type;

   state_type                             state_ff;
   logic                                  side_ff;
   logic [1:0]                            chan_ff;
   logic [bgp_pkg::BIT_CNT_W-1:0]         bit_ff;
   logic                                  neg_ff;
   bgp_pkg::div_state_type                div_ff;
   bgp_pkg::div_state_type                div_in;
   logic [1:0][bgp_pkg::NUM_CHANS-1:0][bgp_pkg::STEP_W-1:0] step_ff;

   logic [bgp_pkg::CHAN_W-1:0]            top_val;
   logic [bgp_pkg::CHAN_W-1:0]            bot_val;
   logic [bgp_pkg::CHAN_W-1:0]            mag;

   always_comb begin
      top_val = bgp_pkg::chan_of(cfg.colour[side_ff ? bgp_pkg::CORNER_TR : bgp_pkg::CORNER_TL],
                                 int'(chan_ff));
      bot_val = bgp_pkg::chan_of(cfg.colour[side_ff ? bgp_pkg::CORNER_BR : bgp_pkg::CORNER_BL],
                                 int'(chan_ff));
      mag     = (bot_val >= top_val) ? bot_val - top_val : top_val - bot_val;
      div_in  = bgp_pkg::div_step(div_ff, hdiv);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= S_LOAD;
         side_ff  <= 1'b0;
         chan_ff  <= 2'd0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               neg_ff     <= bot_val < top_val;
               div_ff.rem <= '0;
               div_ff.num <= {mag, {bgp_pkg::FRAC_BITS{1'b0}}};
               bit_ff     <= '0;
               state_ff   <= S_RUN;
            end
            S_RUN: begin
               div_ff <= div_in;
               bit_ff <= bit_ff + bgp_pkg::BIT_CNT_W'(1);
               if (bit_ff == bgp_pkg::BIT_CNT_W'(bgp_pkg::NUM_W - 1)) begin
                  state_ff <= S_STORE;
               end
            end
            S_STORE: begin
               step_ff[side_ff][chan_ff] <= neg_ff ?
                  bgp_pkg::STEP_W'(0) - {1'b0, div_ff.num} : {1'b0, div_ff.num};
               if (chan_ff == 2'(bgp_pkg::NUM_CHANS - 1)) begin
                  chan_ff <= 2'd0;
                  if (side_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     side_ff  <= 1'b1;
                     state_ff <= S_LOAD;
                  end
               end else begin
                  chan_ff  <= chan_ff + 2'd1;
                  state_ff <= S_LOAD;
               end
            end
            S_IDLE: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign vstep.busy = (state_ff != S_IDLE);
   assign vstep.step = step_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bgp_hdiv_stage.sv =====
`default_nettype none
module bgp_hdiv_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  bgp_pkg::hdiv_beat_type     in_beat,
   input  logic [bgp_pkg::DIV_W-1:0]  divisor,
   output logic                       out_valid,
   output bgp_pkg::hdiv_beat_type     out_beat
);

   logic                   valid_ff;
   bgp_pkg::hdiv_beat_type beat_ff;
   bgp_pkg::hdiv_beat_type beat_in;

   always_comb begin
      beat_in = in_beat;
      for (int ch = 0; ch < bgp_pkg::NUM_CHANS; ch++) begin
         for (int k = 0; k < bgp_pkg::DIV_BITS_PER_STAGE; k++) begin
            beat_in.div[ch] = bgp_pkg::div_step(beat_in.div[ch], divisor);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bilinear_gradient_pixel_unit.sv =====
// Throughput: one pixel per cycle once the vertical steps are ready and while rsp_ready is high.
// A beat is registered in stage A, stage B, stage C, the divide stages D, stage E and the output register in turn.
// The horizontal divide is a 6-stage pipeline retiring 4 quotient bits per stage.
// Reset loads the default size and corners and empties the pipeline; then a serial divider
// computes the six vertical steps with req_ready low. Each csr write repeats it.
`default_nettype none
module bilinear_gradient_pixel_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bgp_pkg::req_beat_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bgp_pkg::rsp_beat_type             rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bgp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgp_pkg::CSR_DATA_W-1:0]    csr_data
);

   `include "bilinear_gradient_pixel_unit_assert.svh"

   localparam int LAST = bgp_pkg::DIV_STAGES - 1;

   bgp_pkg::cfg_type                 cfg_ff;
   logic [bgp_pkg::DIV_W-1:0]        wdiv_ff;
   logic [bgp_pkg::DIV_W-1:0]        hdiv_ff;
   logic                             csr_write;
   bgp_pkg::vstep_type               vstep;

   // Pipeline registers
   logic                             a_valid_ff;
   logic [bgp_pkg::COORD_W-1:0]      a_col_ff;
   logic [bgp_pkg::COORD_W-1:0]      a_row_ff;
   logic                             b_valid_ff;
   logic [bgp_pkg::COORD_W-1:0]      b_col_ff;
   logic [bgp_pkg::NUM_CHANS-1:0][bgp_pkg::NUM_W-1:0] b_left_ff;
   logic [bgp_pkg::NUM_CHANS-1:0][bgp_pkg::NUM_W-1:0] b_right_ff;
   logic [bgp_pkg::NUM_CHANS-1:0][bgp_pkg::NUM_W-1:0] b_left_in;
   logic [bgp_pkg::NUM_CHANS-1:0][bgp_pkg::NUM_W-1:0] b_right_in;
   logic                             c_valid_ff;
   bgp_pkg::hdiv_beat_type           c_beat_ff;
   bgp_pkg::hdiv_beat_type           c_beat_in;
   logic [bgp_pkg::DIV_STAGES-1:0]   d_valid;
   bgp_pkg::hdiv_beat_type           d_beat [bgp_pkg::DIV_STAGES];
   logic [bgp_pkg::DIV_STAGES-1:0]   d_en;
   logic                             e_valid_ff;
   logic [bgp_pkg::NUM_CHANS-1:0][bgp_pkg::SUM_W-1:0] e_v_ff;
   logic [bgp_pkg::NUM_CHANS-1:0][bgp_pkg::SUM_W-1:0] e_v_in;
   logic                             out_valid_ff;
   bgp_pkg::rsp_beat_type            out_beat_ff;
   bgp_pkg::rsp_beat_type            out_beat_in;

   logic                             a_en;
   logic                             b_en;
   logic                             c_en;
   logic                             e_en;
   logic                             out_en;

   function automatic logic [bgp_pkg::NUM_W-1:0] side_value(
      logic [bgp_pkg::CHAN_W-1:0]  corner,
      logic [bgp_pkg::COORD_W-1:0] row,
      logic [bgp_pkg::STEP_W-1:0]  step
   );
      logic signed [bgp_pkg::SUM_W-1:0] prod;
      logic signed [bgp_pkg::SUM_W-1:0] acc;
      prod = bgp_pkg::SUM_W'($signed({1'b0, row}) * $signed(step));
      acc  = $signed({{(bgp_pkg::SUM_W - bgp_pkg::NUM_W){1'b0}}, corner,
                      {bgp_pkg::FRAC_BITS{1'b0}}}) + prod;
      return acc[bgp_pkg::NUM_W-1:0];
   endfunction

   function automatic logic [bgp_pkg::CHAN_W-1:0] saturate(logic [bgp_pkg::SUM_W-1:0] v);
      logic [bgp_pkg::CHAN_W-1:0] r;
      if (v[bgp_pkg::SUM_W-1]) begin
         r = '0;
      end else if (|v[bgp_pkg::SUM_W-2:bgp_pkg::NUM_W]) begin
         r = '1;
      end else begin
         r = v[bgp_pkg::NUM_W-1:bgp_pkg::FRAC_BITS];
      end
      return r;
   endfunction

   // Configuration
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width                      <= bgp_pkg::RESET_WIDTH;
         cfg_ff.height                     <= bgp_pkg::RESET_HEIGHT;
         cfg_ff.colour[bgp_pkg::CORNER_TL] <= bgp_pkg::RESET_TOP_LEFT;
         cfg_ff.colour[bgp_pkg::CORNER_BL] <= bgp_pkg::RESET_BOTTOM_LEFT;
         cfg_ff.colour[bgp_pkg::CORNER_TR] <= bgp_pkg::RESET_TOP_RIGHT;
         cfg_ff.colour[bgp_pkg::CORNER_BR] <= bgp_pkg::RESET_BOTTOM_RIGHT;
      end else if (csr_write) begin
         case (csr_index)
            bgp_pkg::REG_WIDTH:
               cfg_ff.width <= csr_data[bgp_pkg::SIZE_W-1:0];
            bgp_pkg::REG_HEIGHT:
               cfg_ff.height <= csr_data[bgp_pkg::SIZE_W-1:0];
            bgp_pkg::REG_TOP_LEFT:
               cfg_ff.colour[bgp_pkg::CORNER_TL] <= csr_data[bgp_pkg::COLOUR_W-1:0];
            bgp_pkg::REG_BOTTOM_LEFT:
               cfg_ff.colour[bgp_pkg::CORNER_BL] <= csr_data[bgp_pkg::COLOUR_W-1:0];
            bgp_pkg::REG_TOP_RIGHT:
               cfg_ff.colour[bgp_pkg::CORNER_TR] <= csr_data[bgp_pkg::COLOUR_W-1:0];
            bgp_pkg::REG_BOTTOM_RIGHT:
               cfg_ff.colour[bgp_pkg::CORNER_BR] <= csr_data[bgp_pkg::COLOUR_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      wdiv_ff <= bgp_pkg::eff_div(cfg_ff.width);
      hdiv_ff <= bgp_pkg::eff_div(cfg_ff.height);
   end

   bgp_vstep_seq u_vstep (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_write),
      .cfg     (cfg_ff),
      .hdiv    (hdiv_ff),
      .vstep   (vstep)
   );

   // Stall chain: a stage advances when empty or when the next one advances
   assign out_en    = !out_valid_ff || rsp_ready;
   assign e_en      = !e_valid_ff || out_en;
   assign d_en[LAST] = !d_valid[LAST] || e_en;
   for (genvar i = 0; i < LAST; i++) begin : g_den
      assign d_en[i] = !d_valid[i] || d_en[i+1];
   end
   assign c_en      = !c_valid_ff || d_en[0];
   assign b_en      = !b_valid_ff || c_en;
   assign a_en      = !a_valid_ff || b_en;
   assign req_ready = a_en && !vstep.busy;

   // Stage A: saturate coordinates
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_valid && !vstep.busy;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_col_ff <= (req_data.column > wdiv_ff) ? wdiv_ff : req_data.column;
         a_row_ff <= (req_data.row > hdiv_ff) ? hdiv_ff : req_data.row;
      end
   end

   // Stage B: left and right edge colours at the row
   always_comb begin
      for (int ch = 0; ch < bgp_pkg::NUM_CHANS; ch++) begin
         b_left_in[ch]  = side_value(bgp_pkg::chan_of(cfg_ff.colour[bgp_pkg::CORNER_TL], ch),
                                     a_row_ff, vstep.step[0][ch]);
         b_right_in[ch] = side_value(bgp_pkg::chan_of(cfg_ff.colour[bgp_pkg::CORNER_TR], ch),
                                     a_row_ff, vstep.step[1][ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_col_ff   <= a_col_ff;
         b_left_ff  <= b_left_in;
         b_right_ff <= b_right_in;
      end
   end

   // Stage C: sign and magnitude of the horizontal span
   always_comb begin
      c_beat_in.left = b_left_ff;
      c_beat_in.col  = b_col_ff;
      for (int ch = 0; ch < bgp_pkg::NUM_CHANS; ch++) begin
         c_beat_in.neg[ch]     = b_right_ff[ch] < b_left_ff[ch];
         c_beat_in.div[ch].rem = '0;
         c_beat_in.div[ch].num = c_beat_in.neg[ch] ? b_left_ff[ch] - b_right_ff[ch]
                                                   : b_right_ff[ch] - b_left_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_en) begin
         c_beat_ff <= c_beat_in;
      end
   end

   // Stages D: horizontal divide by width minus one
   for (genvar i = 0; i < bgp_pkg::DIV_STAGES; i++) begin : g_div
      if (i == 0) begin : g_first
         bgp_hdiv_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (d_en[i]),
            .in_valid  (c_valid_ff),
            .in_beat   (c_beat_ff),
            .divisor   (wdiv_ff),
            .out_valid (d_valid[i]),
            .out_beat  (d_beat[i])
         );
      end else begin : g_rest
         bgp_hdiv_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .advance   (d_en[i]),
            .in_valid  (d_valid[i-1]),
            .in_beat   (d_beat[i-1]),
            .divisor   (wdiv_ff),
            .out_valid (d_valid[i]),
            .out_beat  (d_beat[i])
         );
      end
   end

   // Stage E: left plus column times signed horizontal step
   always_comb begin
      for (int ch = 0; ch < bgp_pkg::NUM_CHANS; ch++) begin
         logic [bgp_pkg::MUL_W-1:0] prod;
         logic [bgp_pkg::SUM_W-1:0] base;
         prod = bgp_pkg::MUL_W'(d_beat[LAST].col * d_beat[LAST].div[ch].num);
         base = {{(bgp_pkg::SUM_W - bgp_pkg::NUM_W){1'b0}}, d_beat[LAST].left[ch]};
         e_v_in[ch] = d_beat[LAST].neg[ch] ? base - {2'b00, prod} : base + {2'b00, prod};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_en) begin
         e_valid_ff <= d_valid[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (e_en) begin
         e_v_ff <= e_v_in;
      end
   end

   // Output register: floor, clamp and pack
   always_comb begin
      out_beat_in.red       = saturate(e_v_ff[0]);
      out_beat_in.green     = saturate(e_v_ff[1]);
      out_beat_in.blue      = saturate(e_v_ff[2]);
      out_beat_in.argb_word = {bgp_pkg::ALPHA, out_beat_in.red, out_beat_in.green,
                               out_beat_in.blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_beat_ff <= out_beat_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_beat_ff;

   `BGP_ASSERT_NEXT(a_csr_starts_recompute, csr_write, vstep.busy && !req_ready)
   `BGP_ASSERT_NEXT(a_stalled_stage_holds, e_valid_ff && !out_en, e_valid_ff)
   `BGP_ASSERT_NOW(a_argb_matches, rsp_valid, rsp_data.argb_word[31:24] == bgp_pkg::ALPHA && rsp_data.argb_word[23:16] == rsp_data.red && rsp_data.argb_word[7:0] == rsp_data.blue)

endmodule
`default_nettype wire
